[hdl/mkrs_pkg.sv]
`default_nettype none
package mkrs_pkg;

  // Sort key selection codes
  localparam logic [1:0] MODE_KEEP  = 2'd0;
  localparam logic [1:0] MODE_ID    = 2'd1;
  localparam logic [1:0] MODE_NAME  = 2'd2;
  localparam logic [1:0] MODE_GRADE = 2'd3;

  localparam int ID_W    = 20;
  localparam int NAME_W  = 64;
  localparam int GRADE_W = 16;
  localparam int REC_W   = ID_W + NAME_W + GRADE_W;
  localparam int TDATA_W = ((REC_W + 7) / 8) * 8;

  // One record, id in the lowest bits
  typedef struct packed {
    logic signed [GRADE_W-1:0] grade;
    logic [NAME_W-1:0]         name;
    logic [ID_W-1:0]           id;
  } rec_t;

  // True when record x sorts strictly ahead of record y
  function automatic logic goes_before(logic [1:0] mode, rec_t x, rec_t y);
    logic res;
    res = 1'b0;
    case (mode)
      MODE_ID:    res = x.id < y.id;
      MODE_NAME:  res = (x.name != y.name) ? (x.name < y.name) : (x.id < y.id);
      MODE_GRADE: res = (x.grade != y.grade) ? (x.grade < y.grade) : (x.id < y.id);
      default:    res = 1'b0;
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

[hdl/mkrs_ram.sv]
`default_nettype none
module mkrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hdl/mkrs_cmp.sv]
`default_nettype none
module mkrs_cmp (
  input  wire logic [1:0]   mode,
  input  wire mkrs_pkg::rec_t rec_i,
  input  wire mkrs_pkg::rec_t rec_j,
  input  wire logic         j_lt_i,
  output logic              inc
);
  import mkrs_pkg::*;

  logic j_first;
  logic i_first;

  // Record j lands ahead of record i: strictly smaller key, or tied and earlier
  always_comb begin
    j_first = goes_before(mode, rec_j, rec_i);
    i_first = goes_before(mode, rec_i, rec_j);
    inc     = j_first | (j_lt_i & ~i_first);
  end

endmodule
`default_nettype wire

[hdl/multi_key_record_sorter_core.sv]
// Multi-key record sorter.
// Records arrive as beats on the in_ channel (tdata: id, name, grade; tlast
// closes a batch) and are written into a record memory, one beat per cycle.
// Beyond MAX_RECORDS held records, further beats are taken and dropped.
// After the tlast beat the block ranks every held record: each record is
// compared against every other, one pair per cycle through two read ports
// of duplicated record memories, and each record is then written to its
// rank in an output memory. The sorted batch then leaves on the out_
// channel one beat at a time, each read from the output memory into the
// output register before it is offered, tlast on the final record.
// Equal keys keep arrival order. cfg_wr_en/cfg_wr_data set the sort mode
// (0 arrival order, 1 id, 2 name then id, 3 grade then id), used while
// ranking. in_tready is low from the tlast beat until the last sorted beat
// is taken. A stalled receiver holds the output register and the sequence.
// Reset empties the batch and sets mode 1; memories are not cleared.
`default_nettype none
module multi_key_record_sorter_core #(
  parameter int MAX_RECORDS = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // in_tdata fields from bit 0: rec_id[19:0], rec_name[63:0], rec_grade[15:0]
  input  wire logic [mkrs_pkg::TDATA_W-1:0] in_tdata,
  input  wire logic                         in_tvalid,
  input  wire logic                         in_tlast,
  output logic                              in_tready,
  // out_tdata fields from bit 0: out_id[19:0], out_name[63:0], out_grade[15:0]
  output logic      [mkrs_pkg::TDATA_W-1:0] out_tdata,
  output logic                              out_tvalid,
  output logic                              out_tlast,
  input  wire logic                         out_tready,
  input  wire logic                         cfg_wr_en,
  input  wire logic [1:0]                   cfg_wr_data
);
  import mkrs_pkg::*;

  localparam int AW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);

  typedef enum logic [4:0] {
    S_LOAD = 5'b00001,
    S_SORT = 5'b00010,
    S_RD   = 5'b00100,
    S_LD   = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   n_r, n_nxt;
  logic [1:0]      mode_r, mode_nxt;
  logic [AW-1:0]   i_r, i_nxt, j_r, j_nxt;
  logic            iss_r, iss_nxt;
  logic            p1_vld_r, p1_lt_r, p1_jl_r, p1_il_r;
  logic            p2_vld_r, p2_inc_r, p2_jl_r, p2_il_r;
  rec_t            p2_rec_r;
  logic [AW-1:0]   rank_r, rank_nxt;
  logic [AW-1:0]   k_r, k_nxt;
  logic            last_r, last_nxt;
  rec_t            out_rec_r;

  logic            in_acc, out_acc;
  logic [CW-1:0]   nm1_full;
  logic [AW-1:0]   nm1;
  logic            store_we;
  logic [REC_W-1:0] rd_a, rd_b, rd_s;
  logic            inc_w;
  logic [AW-1:0]   rank_tot;
  logic            sort_we;
  logic [AW-1:0]   s_raddr;

  assign in_acc   = in_tvalid & in_tready;
  assign out_acc  = out_tvalid & out_tready;
  assign nm1_full = n_r - CW'(1);
  assign nm1      = nm1_full[AW-1:0];
  assign store_we = in_acc & (cnt_r < CW'(MAX_RECORDS));
  assign rank_tot = rank_r + AW'(p2_inc_r);
  assign sort_we  = p2_vld_r & p2_jl_r;
  assign s_raddr  = (state_r == S_OUT) ? (k_r + AW'(1)) : k_r;

  // Record memories, duplicated for two read addresses per cycle
  mkrs_ram #(.WIDTH(REC_W), .DEPTH(MAX_RECORDS)) u_ram_a (
    .clk(clk), .we(store_we), .waddr(cnt_r[AW-1:0]), .wdata(in_tdata[REC_W-1:0]),
    .raddr(i_r), .rdata(rd_a)
  );
  mkrs_ram #(.WIDTH(REC_W), .DEPTH(MAX_RECORDS)) u_ram_b (
    .clk(clk), .we(store_we), .waddr(cnt_r[AW-1:0]), .wdata(in_tdata[REC_W-1:0]),
    .raddr(j_r), .rdata(rd_b)
  );
  // Output memory addressed by rank
  mkrs_ram #(.WIDTH(REC_W), .DEPTH(MAX_RECORDS)) u_ram_s (
    .clk(clk), .we(sort_we), .waddr(rank_tot), .wdata(p2_rec_r),
    .raddr(s_raddr), .rdata(rd_s)
  );

  mkrs_cmp u_cmp (
    .mode(mode_r), .rec_i(rec_t'(rd_a)), .rec_j(rec_t'(rd_b)),
    .j_lt_i(p1_lt_r), .inc(inc_w)
  );

  // Control sequencing
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    mode_nxt  = cfg_wr_en ? cfg_wr_data : mode_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    iss_nxt   = iss_r;
    rank_nxt  = rank_r;
    k_nxt     = k_r;
    last_nxt  = last_r;
    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (store_we) cnt_nxt = cnt_r + CW'(1);
          if (in_tlast) begin
            n_nxt     = store_we ? (cnt_r + CW'(1)) : cnt_r;
            i_nxt     = '0;
            j_nxt     = '0;
            iss_nxt   = 1'b1;
            rank_nxt  = '0;
            state_nxt = S_SORT;
          end
        end
      end
      S_SORT: begin
        if (iss_r) begin
          if (j_r == nm1) begin
            j_nxt = '0;
            if (i_r == nm1) iss_nxt = 1'b0;
            else            i_nxt   = i_r + AW'(1);
          end else begin
            j_nxt = j_r + AW'(1);
          end
        end
        if (p2_vld_r) begin
          rank_nxt = p2_jl_r ? '0 : rank_tot;
          if (p2_jl_r && p2_il_r) begin
            k_nxt     = '0;
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_LD;
      end
      S_LD: begin
        last_nxt  = (k_r == nm1);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_acc) begin
          if (last_r) begin
            cnt_nxt   = '0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_r + AW'(1);
            state_nxt = S_LD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      cnt_r    <= '0;
      mode_r   <= MODE_ID;
      iss_r    <= 1'b0;
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      mode_r   <= mode_nxt;
      iss_r    <= iss_nxt;
      p1_vld_r <= (state_r == S_SORT) & iss_r;
      p2_vld_r <= p1_vld_r;
    end
  end

  // Datapath registers: indices, rank pipeline, output record
  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    rank_r   <= rank_nxt;
    k_r      <= k_nxt;
    last_r   <= last_nxt;
    p1_lt_r  <= j_r < i_r;
    p1_jl_r  <= j_r == nm1;
    p1_il_r  <= i_r == nm1;
    p2_inc_r <= inc_w;
    p2_jl_r  <= p1_jl_r;
    p2_il_r  <= p1_il_r;
    p2_rec_r <= rec_t'(rd_a);
    if (state_r == S_LD) out_rec_r <= rec_t'(rd_s);
  end

  assign in_tready  = (state_r == S_LOAD);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tlast  = last_r;
  assign out_tdata  = TDATA_W'(out_rec_r);

  // Checks
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while a sorted beat is pending");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_RECORDS))
    else $error("record count beyond capacity");

  a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SORT) && sort_we |-> (CW'(rank_tot) < n_r))
    else $error("rank outside the batch");

  a_batch_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && out_tlast |=> in_tready)
    else $error("block not ready after final sorted beat");

endmodule
`default_nettype wire
